// ===== rtl/core/deadline_task_scheduler_defines.svh =====
// ----------------------------------------------------------------------------
// deadline_task_scheduler_defines
// assertion macros shared by the deadline task scheduler rtl
// ----------------------------------------------------------------------------
`ifndef DEADLINE_TASK_SCHEDULER_DEFINES_SVH
`define DEADLINE_TASK_SCHEDULER_DEFINES_SVH

// condition holds at every edge outside reset
`define DTS_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequence holds at the edge after the trigger
`define DTS_ASSERT_NEXT(label, clk, rst_n, trig, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/dts_pkg.sv =====
// ----------------------------------------------------------------------------
// dts_pkg
// opcodes, cell commands and fixed field widths of the deadline task scheduler
// ----------------------------------------------------------------------------
package dts_pkg;

    localparam int OP_BITS    = 3;
    localparam int DL_BITS    = 32;
    localparam int PORT_ID_BITS = 8;
    localparam int COUNT_BITS = 4;

    typedef enum logic [OP_BITS-1:0] {
        OP_ADD       = 3'd0,
        OP_REMOVE    = 3'd1,
        OP_PICK      = 3'd2,
        OP_DONE_OK   = 3'd3,
        OP_DONE_FAIL = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        CELL_HOLD  = 2'd0,
        CELL_LOAD  = 2'd1,
        CELL_SHIFT = 2'd2,
        CELL_RENEW = 2'd3
    } cell_cmd_t;

    typedef struct packed {
        cell_cmd_t cmd;
        logic      in_use;
        logic      is_pick;
    } cell_ctl_t;

endpackage

// ===== rtl/core/dts_cell.sv =====
// ----------------------------------------------------------------------------
// dts_cell
// one task slot plus one stage of the search chain that walks the table
// ----------------------------------------------------------------------------
module dts_cell #(
    parameter int ID_BITS   = 8,
    parameter int SLOT_BITS = 3
) (
    input  logic                          clk,
    input  dts_pkg::cell_ctl_t            ctl,
    input  logic [SLOT_BITS-1:0]          slot_idx,
    input  logic [ID_BITS-1:0]            key,
    input  logic [dts_pkg::DL_BITS-1:0]   now,
    input  logic [ID_BITS-1:0]            new_id,
    input  logic [dts_pkg::DL_BITS-1:0]   new_deadline,
    input  logic [dts_pkg::DL_BITS-1:0]   new_period,
    input  logic [ID_BITS-1:0]            nbr_id,
    input  logic [dts_pkg::DL_BITS-1:0]   nbr_deadline,
    input  logic [dts_pkg::DL_BITS-1:0]   nbr_period,
    output logic [ID_BITS-1:0]            id,
    output logic [dts_pkg::DL_BITS-1:0]   deadline,
    output logic [dts_pkg::DL_BITS-1:0]   period,
    input  logic                          tin_found,
    input  logic [SLOT_BITS-1:0]          tin_slot,
    input  logic [dts_pkg::DL_BITS-1:0]   tin_deadline,
    input  logic [ID_BITS-1:0]            tin_id,
    output logic                          tout_found,
    output logic [SLOT_BITS-1:0]          tout_slot,
    output logic [dts_pkg::DL_BITS-1:0]   tout_deadline,
    output logic [ID_BITS-1:0]            tout_id
);

    logic [ID_BITS-1:0]          id_reg, id_next;
    logic [dts_pkg::DL_BITS-1:0] dl_reg, dl_next;
    logic [dts_pkg::DL_BITS-1:0] per_reg, per_next;

    logic                        found_reg, found_next;
    logic [SLOT_BITS-1:0]        slot_reg, slot_next;
    logic [dts_pkg::DL_BITS-1:0] best_dl_reg, best_dl_next;
    logic [ID_BITS-1:0]          best_id_reg, best_id_next;

    logic [dts_pkg::DL_BITS-1:0] diff_now;
    logic [dts_pkg::DL_BITS-1:0] diff_best;
    logic                        ready;
    logic                        earlier;
    logic                        take;

    // wraparound compares: sign bit of the 32-bit difference
    assign diff_now  = now - dl_reg;
    assign diff_best = dl_reg - tin_deadline;
    assign ready     = !diff_now[dts_pkg::DL_BITS-1];
    assign earlier   = diff_best[dts_pkg::DL_BITS-1];

    always_comb
    begin
        if (ctl.is_pick)
        begin
            take = ctl.in_use && ready && (!tin_found || earlier);
        end
        else
        begin
            take = ctl.in_use && !tin_found && (id_reg == key);
        end
    end

    always_comb
    begin
        if (take)
        begin
            found_next   = 1'b1;
            slot_next    = slot_idx;
            best_dl_next = dl_reg;
            best_id_next = id_reg;
        end
        else
        begin
            found_next   = tin_found;
            slot_next    = tin_slot;
            best_dl_next = tin_deadline;
            best_id_next = tin_id;
        end
    end

    always_comb
    begin
        id_next  = id_reg;
        dl_next  = dl_reg;
        per_next = per_reg;
        unique case (ctl.cmd)
            dts_pkg::CELL_HOLD:
            begin
            end
            dts_pkg::CELL_LOAD:
            begin
                id_next  = new_id;
                dl_next  = new_deadline;
                per_next = new_period;
            end
            dts_pkg::CELL_SHIFT:
            begin
                id_next  = nbr_id;
                dl_next  = nbr_deadline;
                per_next = nbr_period;
            end
            dts_pkg::CELL_RENEW:
            begin
                dl_next = now + per_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        id_reg      <= id_next;
        dl_reg      <= dl_next;
        per_reg     <= per_next;
        found_reg   <= found_next;
        slot_reg    <= slot_next;
        best_dl_reg <= best_dl_next;
        best_id_reg <= best_id_next;
    end

    assign id            = id_reg;
    assign deadline      = dl_reg;
    assign period        = per_reg;
    assign tout_found    = found_reg;
    assign tout_slot     = slot_reg;
    assign tout_deadline = best_dl_reg;
    assign tout_id       = best_id_reg;

endmodule

// ===== rtl/core/deadline_task_scheduler.sv =====
// ----------------------------------------------------------------------------
// deadline_task_scheduler
// earliest-deadline-first table of periodic tasks with add, remove, pick
// and completion
// ----------------------------------------------------------------------------
// The task table is a row of MAX_TASKS slot cells. Every word walks a search
// token down the row, one cell per clock, to find an id or the ready task with
// the earliest deadline (32-bit wraparound compare, lowest slot on a tie).
// A word is latched on acceptance, then the token passes every cell, and a
// final step commits the table update and loads the result register before
// the next word is accepted. The result sits in its own register, so the
// next word is taken while it waits; a result still held by rsp_stall when
// the next word finishes its walk delays that commit.
// Removal compacts the table at the commit, as the hole and every live cell
// above it but the top one load their upper neighbor.
// ----------------------------------------------------------------------------
`include "deadline_task_scheduler_defines.svh"

module deadline_task_scheduler #(
    parameter int MAX_TASKS = 8,
    parameter int ID_BITS   = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              req_valid,
    output logic                              req_stall,
    input  logic [dts_pkg::OP_BITS-1:0]       opcode,
    input  logic [dts_pkg::PORT_ID_BITS-1:0]  task_id,
    input  logic [dts_pkg::DL_BITS-1:0]       first_deadline,
    input  logic [dts_pkg::DL_BITS-1:0]       task_period,
    input  logic [dts_pkg::DL_BITS-1:0]       now,
    output logic                              rsp_valid,
    input  logic                              rsp_stall,
    output logic                              ok,
    output logic                              found,
    output logic [dts_pkg::PORT_ID_BITS-1:0]  chosen_id,
    output logic [dts_pkg::COUNT_BITS-1:0]    task_count
);

    localparam int SW   = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CNTW = $clog2(MAX_TASKS + 1);
    localparam int DLW  = dts_pkg::DL_BITS;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } state_t;

    state_t                     state_reg, state_next;
    logic [SW-1:0]              cnt_reg, cnt_next;
    logic [CNTW-1:0]            count_reg, count_next;
    logic [SW-1:0]              pend_slot_reg, pend_slot_next;
    logic                       pend_valid_reg, pend_valid_next;
    logic                       rsp_valid_reg, rsp_valid_next;

    logic [dts_pkg::OP_BITS-1:0] op_reg;
    logic [ID_BITS-1:0]          key_reg;
    logic [DLW-1:0]              new_dl_reg;
    logic [DLW-1:0]              new_per_reg;
    logic [DLW-1:0]              now_reg;

    logic                               ok_reg, ok_next;
    logic                               found_reg, found_next;
    logic [dts_pkg::PORT_ID_BITS-1:0]   chosen_reg, chosen_next;
    logic [dts_pkg::COUNT_BITS-1:0]     task_count_reg;

    logic acc;
    logic commit;
    logic pend_ok;
    logic do_load;
    logic do_drop;
    logic do_renew;
    logic [SW-1:0] drop_slot;

    dts_pkg::cell_ctl_t cell_ctl [MAX_TASKS];

    logic [ID_BITS-1:0] c_id  [MAX_TASKS];
    logic [DLW-1:0]     c_dl  [MAX_TASKS];
    logic [DLW-1:0]     c_per [MAX_TASKS];

    logic               tk_found [MAX_TASKS+1];
    logic [SW-1:0]      tk_slot  [MAX_TASKS+1];
    logic [DLW-1:0]     tk_dl    [MAX_TASKS+1];
    logic [ID_BITS-1:0] tk_id    [MAX_TASKS+1];

    assign acc       = req_valid && !req_stall;
    assign req_stall = (state_reg != S_IDLE);
    assign commit    = (state_reg == S_DONE) && (!rsp_valid_reg || !rsp_stall);
    assign pend_ok   = pend_valid_reg && (CNTW'(pend_slot_reg) < count_reg);

    // empty token enters the head of the chain
    assign tk_found[0] = 1'b0;
    assign tk_slot[0]  = '0;
    assign tk_dl[0]    = '0;
    assign tk_id[0]    = '0;

    for (genvar k = 0; k < MAX_TASKS; k++)
    begin : g_cell
        logic [ID_BITS-1:0] nbr_id;
        logic [DLW-1:0]     nbr_dl;
        logic [DLW-1:0]     nbr_per;

        if (k + 1 < MAX_TASKS)
        begin : g_nbr
            assign nbr_id  = c_id[k+1];
            assign nbr_dl  = c_dl[k+1];
            assign nbr_per = c_per[k+1];
        end
        else
        begin : g_last
            assign nbr_id  = '0;
            assign nbr_dl  = '0;
            assign nbr_per = '0;
        end

        dts_cell #(
            .ID_BITS   (ID_BITS),
            .SLOT_BITS (SW)
        ) u_cell (
            .clk           (clk),
            .ctl           (cell_ctl[k]),
            .slot_idx      (SW'(k)),
            .key           (key_reg),
            .now           (now_reg),
            .new_id        (key_reg),
            .new_deadline  (new_dl_reg),
            .new_period    (new_per_reg),
            .nbr_id        (nbr_id),
            .nbr_deadline  (nbr_dl),
            .nbr_period    (nbr_per),
            .id            (c_id[k]),
            .deadline      (c_dl[k]),
            .period        (c_per[k]),
            .tin_found     (tk_found[k]),
            .tin_slot      (tk_slot[k]),
            .tin_deadline  (tk_dl[k]),
            .tin_id        (tk_id[k]),
            .tout_found    (tk_found[k+1]),
            .tout_slot     (tk_slot[k+1]),
            .tout_deadline (tk_dl[k+1]),
            .tout_id       (tk_id[k+1])
        );
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                cnt_next = '0;
                if (acc)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (cnt_reg == SW'(MAX_TASKS - 1))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg + SW'(1);
                end
            end
            S_DONE:
            begin
                if (commit)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // outcome of the word, from the token at the tail of the chain
    always_comb
    begin
        ok_next         = 1'b0;
        found_next      = 1'b0;
        chosen_next     = '0;
        do_load         = 1'b0;
        do_drop         = 1'b0;
        do_renew        = 1'b0;
        drop_slot       = pend_slot_reg;
        count_next      = count_reg;
        pend_valid_next = pend_valid_reg;
        pend_slot_next  = pend_slot_reg;
        unique case (dts_pkg::op_t'(op_reg))
            dts_pkg::OP_ADD:
            begin
                if (!tk_found[MAX_TASKS] && (count_reg < CNTW'(MAX_TASKS)))
                begin
                    do_load    = 1'b1;
                    count_next = count_reg + CNTW'(1);
                    ok_next    = 1'b1;
                end
            end
            dts_pkg::OP_REMOVE:
            begin
                if (tk_found[MAX_TASKS])
                begin
                    do_drop         = 1'b1;
                    drop_slot       = tk_slot[MAX_TASKS];
                    count_next      = count_reg - CNTW'(1);
                    pend_valid_next = 1'b0;
                    ok_next         = 1'b1;
                end
            end
            dts_pkg::OP_PICK:
            begin
                if (tk_found[MAX_TASKS])
                begin
                    ok_next         = 1'b1;
                    found_next      = 1'b1;
                    chosen_next     = dts_pkg::PORT_ID_BITS'(tk_id[MAX_TASKS]);
                    pend_slot_next  = tk_slot[MAX_TASKS];
                    pend_valid_next = 1'b1;
                end
                else
                begin
                    pend_valid_next = 1'b0;
                end
            end
            dts_pkg::OP_DONE_OK:
            begin
                if (pend_ok)
                begin
                    do_renew = 1'b1;
                    ok_next  = 1'b1;
                end
                pend_valid_next = 1'b0;
            end
            dts_pkg::OP_DONE_FAIL:
            begin
                if (pend_ok)
                begin
                    do_drop    = 1'b1;
                    count_next = count_reg - CNTW'(1);
                    ok_next    = 1'b1;
                end
                pend_valid_next = 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    // per-slot commands; compaction shifts every live cell above the hole
    always_comb
    begin
        logic [CNTW-1:0] kk;
        for (int k = 0; k < MAX_TASKS; k++)
        begin
            kk                 = CNTW'(k);
            cell_ctl[k].in_use  = (kk < count_reg);
            cell_ctl[k].is_pick = (op_reg == dts_pkg::OP_PICK);
            cell_ctl[k].cmd     = dts_pkg::CELL_HOLD;
            if (commit)
            begin
                priority if (do_load && (kk == count_reg))
                begin
                    cell_ctl[k].cmd = dts_pkg::CELL_LOAD;
                end
                else if (do_renew && (kk == CNTW'(pend_slot_reg)))
                begin
                    cell_ctl[k].cmd = dts_pkg::CELL_RENEW;
                end
                else if (do_drop && (kk >= CNTW'(drop_slot)) &&
                         ((kk + CNTW'(1)) < count_reg))
                begin
                    cell_ctl[k].cmd = dts_pkg::CELL_SHIFT;
                end
                else
                begin
                    cell_ctl[k].cmd = dts_pkg::CELL_HOLD;
                end
            end
        end
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (commit)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cnt_reg        <= '0;
            count_reg      <= '0;
            pend_slot_reg  <= '0;
            pend_valid_reg <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            rsp_valid_reg <= rsp_valid_next;
            if (commit)
            begin
                count_reg      <= count_next;
                pend_slot_reg  <= pend_slot_next;
                pend_valid_reg <= pend_valid_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            op_reg      <= opcode;
            key_reg     <= ID_BITS'(task_id);
            new_dl_reg  <= first_deadline;
            new_per_reg <= task_period;
            now_reg     <= now;
        end
        if (commit)
        begin
            ok_reg         <= ok_next;
            found_reg      <= found_next;
            chosen_reg     <= chosen_next;
            task_count_reg <= dts_pkg::COUNT_BITS'(count_next);
        end
    end

    assign rsp_valid  = rsp_valid_reg;
    assign ok         = ok_reg;
    assign found      = found_reg;
    assign chosen_id  = chosen_reg;
    assign task_count = task_count_reg;

    `DTS_ASSERT_ALWAYS(a_pend_in_table, clk, rst_n, !pend_valid_reg || (CNTW'(pend_slot_reg) < count_reg), "pending pick points past the table")
    `DTS_ASSERT_NEXT(a_count_on_commit, clk, rst_n, !commit, $stable(count_reg), "task count changed without a commit")
    `DTS_ASSERT_NEXT(a_accept_starts_scan, clk, rst_n, acc, state_reg == S_SCAN, "accepted word did not start the chain walk")

endmodule
